// ===== hdl/sorted_table_binary_search_core_macros.svh =====
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Property that holds on every sampled edge.
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition on one edge implies a property on the next.
`define STBS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/stbs_pkg.sv =====
package stbs_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned KeyBytesDef = 8;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_LIST   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [63:0] key;
    logic [43:0] id_number;
    logic [15:0] page_count;
    logic [26:0] price_cents;
  } rec_t;

  localparam int unsigned RecWidth = $bits(rec_t);

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] key;
    logic [43:0] id_number;
    logic [15:0] page_count;
    logic [26:0] price_cents;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [63:0] found_key;
    logic [43:0] found_id;
    logic [15:0] found_pages;
    logic [26:0] found_price;
    logic        last;
  } result_t;

endpackage

// ===== hdl/stbs_ram.sv =====
module stbs_ram #(
  parameter int unsigned WIDTH = stbs_pkg::RecWidth,
  parameter int unsigned DEPTH = stbs_pkg::CapacityDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sorted_table_binary_search_core.sv =====
// Sorted record table in one single-port-write, registered-read memory. A command word is
// taken when start_i is high and busy_o is low; every result word is shown for one cycle
// with result_valid_o and cannot be held off, so the receiver must take it when it comes.
// Insert moves every larger entry up by one place before writing the new one; update and
// lookup run a binary search over the stored entries; delete searches the same way and then
// moves every later entry down by one place; list all gives one result word per entry, the
// final word flagged with last. A full table (insert) or an empty one (delete, list) gives
// a single error word; unknown operation codes give no result word.
// No clearing pass is needed after reset.
`include "sorted_table_binary_search_core_macros.svh"

module sorted_table_binary_search_core #(
  parameter int unsigned CAPACITY  = stbs_pkg::CapacityDef,
  parameter int unsigned KEY_BYTES = stbs_pkg::KeyBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  stbs_pkg::cmd_t    cmd_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output stbs_pkg::result_t result_o
);

  import stbs_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SRCH    = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_DEL     = 3'd3;
  localparam logic [2:0] S_LIST    = 3'd4;
  localparam logic [2:0] S_INS_CHK = 3'd5;
  localparam logic [2:0] S_INS_PUT = 3'd6;

  function automatic result_t mk_res(logic [1:0] st, logic [5:0] pos, rec_t r, logic lst);
    result_t res;
    res.status      = st;
    res.position    = pos;
    res.found_key   = r.key;
    res.found_id    = r.id_number;
    res.found_pages = r.page_count;
    res.found_price = r.price_cents;
    res.last        = lst;
    return res;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [IW-1:0] mid_q, mid_d;
  cmd_t          cmd_q, cmd_d;
  result_t       res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  rec_t                ram_wdata;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [RecWidth-1:0] ram_rdata;
  rec_t                rd_rec;
  rec_t                new_rec;
  rec_t                upd_rec;
  logic [CW:0]         mid_sum;
  logic [IW-1:0]       mid_w;
  logic [CW-1:0]       p_m1;
  logic [CW-1:0]       mid_p1;

  stbs_ram #(
    .WIDTH(RecWidth),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rec  = rec_t'(ram_rdata);
  assign new_rec = '{key: cmd_q.key, id_number: cmd_q.id_number,
                     page_count: cmd_q.page_count, price_cents: cmd_q.price_cents};
  always_comb begin
    upd_rec             = rd_rec;
    upd_rec.price_cents = cmd_q.price_cents;
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CW + 1)'(1);
  assign mid_w   = IW'(mid_sum >> 1);
  assign p_m1    = p_q - CW'(1);
  assign mid_p1  = CW'(mid_q) + CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    p_d         = p_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = rd_rec;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d     = cmd_i;
          cmd_d.key = cmd_i.key & KeyMask;
          unique case (cmd_i.operation)
            OP_INSERT: begin
              if (count_q >= CapCount) begin
                res_d       = mk_res(ST_FULL, '0, '0, 1'b1);
                res_valid_d = 1'b1;
              end else begin
                p_d = count_q;
                if (count_q == '0) begin
                  state_d = S_INS_PUT;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = IW'(count_q - CW'(1));
                  state_d   = S_INS_CHK;
                end
              end
            end
            OP_UPDATE, OP_LOOKUP: begin
              lo_d    = '0;
              hi_d    = count_q;
              state_d = S_SRCH;
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                res_d       = mk_res(ST_EMPTY, '0, '0, 1'b1);
                res_valid_d = 1'b1;
              end else begin
                lo_d    = '0;
                hi_d    = count_q;
                state_d = S_SRCH;
              end
            end
            OP_LIST: begin
              if (count_q == '0) begin
                res_d       = mk_res(ST_EMPTY, '0, '0, 1'b1);
                res_valid_d = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                p_d       = '0;
                state_d   = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SRCH: begin
        if (lo_q >= hi_q) begin
          res_d       = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = mid_w;
          mid_d     = mid_w;
          state_d   = S_CMP;
        end
      end

      S_CMP: begin
        if (cmd_q.key == rd_rec.key) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          if (cmd_q.operation == OP_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = mid_q;
            ram_wdata = upd_rec;
            res_d     = mk_res(ST_OK, 6'(mid_q), upd_rec, 1'b1);
          end else begin
            res_d = mk_res(ST_OK, 6'(mid_q), rd_rec, 1'b1);
            if (cmd_q.operation == OP_DELETE) begin
              if (mid_p1 < count_q) begin
                ram_re    = 1'b1;
                ram_raddr = IW'(mid_p1);
                p_d       = CW'(mid_q);
                state_d   = S_DEL;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
          end
        end else if (cmd_q.key < rd_rec.key) begin
          hi_d    = CW'(mid_q);
          state_d = S_SRCH;
        end else begin
          lo_d    = mid_p1;
          state_d = S_SRCH;
        end
      end

      S_DEL: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(p_q);
        ram_wdata = rd_rec;
        if (p_q + CW'(2) < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(p_q + CW'(2));
          p_d       = p_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end
      end

      S_LIST: begin
        res_valid_d = 1'b1;
        res_d       = mk_res(ST_OK, 6'(p_q), rd_rec, p_q + CW'(1) == count_q);
        if (p_q + CW'(1) == count_q) begin
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(p_q + CW'(1));
          p_d       = p_q + CW'(1);
        end
      end

      S_INS_CHK: begin
        ram_we = 1'b1;
        ram_waddr = IW'(p_q);
        if (cmd_q.key < rd_rec.key) begin
          ram_wdata = rd_rec;
          p_d       = p_m1;
          if (p_m1 == '0) begin
            state_d = S_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IW'(p_q - CW'(2));
          end
        end else begin
          ram_wdata   = new_rec;
          res_d       = mk_res(ST_OK, 6'(p_q), new_rec, 1'b1);
          res_valid_d = 1'b1;
          count_d     = count_q + CW'(1);
          state_d     = S_IDLE;
        end
      end

      S_INS_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = IW'(p_q);
        ram_wdata   = new_rec;
        res_d       = mk_res(ST_OK, 6'(p_q), new_rec, 1'b1);
        res_valid_d = 1'b1;
        count_d     = count_q + CW'(1);
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `STBS_ASSERT(a_count_cap, count_q <= CapCount, "entry count above capacity")
  `STBS_ASSERT(a_no_write_idle, !(ram_we && state_q == S_IDLE), "memory write while idle")
  `STBS_ASSERT_NEXT(a_ins_count, state_q == S_INS_PUT,
                    count_q == $past(count_q) + CW'(1), "insert did not grow table")
  `STBS_ASSERT_NEXT(a_list_word, state_q == S_LIST, result_valid_o, "list step gave no word")
  `STBS_ASSERT(a_err_word, !(result_valid_o && result_o.status != ST_OK &&
               (!result_o.last || result_o.position != '0)), "error word not final or not cleared")

endmodule
